FILE: src/pmns_pkg.sv
// Package for the palette-mapped nearest-neighbour scaler.
// Holds the types, constants and axis-step function for front, back and top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmns_pkg;

  localparam int unsigned CACHE_WIDTH_DEF = 256;
  localparam int unsigned CACHE_ROWS_DEF  = 256;
  localparam int unsigned MAX_SCREEN_DEF  = 1024;

  localparam int unsigned POS_W   = 18;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned SPAN_W  = 24;
  localparam int unsigned START_W = 17;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam int unsigned CACHE_DEPTH = 1 << ADDR_W;
  localparam int unsigned PAL_DEPTH   = 1 << BYTE_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_DEPTH   = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(160);
  localparam logic [POS_W-1:0]  ONE_FP8    = POS_W'(256);

  typedef enum logic [1:0] {
    MODE_CACHE_WR = 2'd0,
    MODE_PAL_WR   = 2'd1,
    MODE_TICK     = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_START_COL     = 3'd0,
    REG_START_ROW     = 3'd1,
    REG_SPAN_COLS     = 3'd2,
    REG_SPAN_ROWS     = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } reg_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel;
    logic              row_end;
    logic              frame_end;
  } result_t;

  typedef struct packed {
    logic signed [START_W-1:0] start_col_fp8;
    logic signed [START_W-1:0] start_row_fp8;
    logic signed [SPAN_W-1:0]  span_cols_fp8;
    logic signed [SPAN_W-1:0]  span_rows_fp8;
    logic [SIZE_W-1:0]         screen_width;
    logic [SIZE_W-1:0]         screen_height;
  } cfg_t;

  typedef struct packed {
    mode_e             op;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              row_end;
    logic              frame_end;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [ACC_W-1:0] acc;
  } axis_t;

  // Saturating accumulate, then one source-pixel step when past the limit
  function automatic axis_t step_axis(input logic [POS_W-1:0]  pos,
                                      input logic [ACC_W-1:0]  acc,
                                      input logic [SPAN_W-1:0] step,
                                      input logic              back,
                                      input logic [ACC_W-1:0]  limit);
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] sat;
    axis_t            res;
    sum = {1'b0, acc} + (ACC_W+1)'(step);
    sat = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
    res.pos = pos;
    res.acc = sat;
    if (sat > limit) begin
      res.acc = sat - limit;
      res.pos = back ? pos - ONE_FP8 : pos + ONE_FP8;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/pmns_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pmns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/pmns_fifo.sv
// Small register FIFO used for the command queue and the result buffer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pmns_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/pmns_front.sv
// Front end: takes items, tracks source position and screen counters,
// turns each item of a known mode into a memory command. Depends on pmns_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmns_front import pmns_pkg::*; #(
  parameter int unsigned CACHE_WIDTH = CACHE_WIDTH_DEF,
  parameter int unsigned CACHE_ROWS  = CACHE_ROWS_DEF,
  parameter int unsigned MAX_SCREEN  = MAX_SCREEN_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_push_i,
  input  wire item_t item_i,
  output logic       item_full_o,
  input  wire cfg_t  cfg_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o,
  input  wire logic  cmd_full_i
);

  localparam int unsigned DIM_W = $clog2(MAX_SCREEN + 1);
  localparam int unsigned CNT_W = $clog2(MAX_SCREEN);
  localparam int unsigned LIM_W = DIM_W + 8;
  localparam logic [POS_W-1:0]  ROW_CLAMP = POS_W'((CACHE_ROWS - 1) * 256);
  localparam logic [ADDR_W-1:0] CW16      = ADDR_W'(CACHE_WIDTH);

  function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_SCREEN) begin
      r = DIM_W'(MAX_SCREEN);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // settings derived from the registers, registered once more behind them
  logic [DIM_W-1:0]  w_eff_q, w_eff_d, h_eff_q, h_eff_d;
  logic [LIM_W-1:0]  col_init_q, col_init_d, row_init_q, row_init_d;
  logic [POS_W-1:0]  col_start_q, col_start_d, row_start_q, row_start_d;
  logic [SPAN_W-1:0] col_mag_q, col_mag_d, row_mag_q, row_mag_d;
  logic              col_neg_q, col_neg_d, row_neg_q, row_neg_d;
  logic [LIM_W-1:0]  col_frac, row_frac;

  always_comb begin
    w_eff_d     = eff_size(cfg_i.screen_width);
    h_eff_d     = eff_size(cfg_i.screen_height);
    col_neg_d   = cfg_i.span_cols_fp8[SPAN_W-1];
    row_neg_d   = cfg_i.span_rows_fp8[SPAN_W-1];
    col_mag_d   = col_neg_d ? SPAN_W'(-cfg_i.span_cols_fp8) : SPAN_W'(cfg_i.span_cols_fp8);
    row_mag_d   = row_neg_d ? SPAN_W'(-cfg_i.span_rows_fp8) : SPAN_W'(cfg_i.span_rows_fp8);
    col_start_d = {cfg_i.start_col_fp8[START_W-1], cfg_i.start_col_fp8};
    row_start_d = {cfg_i.start_row_fp8[START_W-1], cfg_i.start_row_fp8};
    col_frac    = LIM_W'(cfg_i.start_col_fp8[7:0]) * LIM_W'(w_eff_d);
    row_frac    = LIM_W'(cfg_i.start_row_fp8[7:0]) * LIM_W'(h_eff_d);
    col_init_d  = col_neg_d ? {w_eff_d, 8'd0} - col_frac : col_frac;
    row_init_d  = row_neg_d ? {h_eff_d, 8'd0} - row_frac : row_frac;
  end

  always_ff @(posedge clk_i) begin
    w_eff_q     <= w_eff_d;
    h_eff_q     <= h_eff_d;
    col_init_q  <= col_init_d;
    row_init_q  <= row_init_d;
    col_start_q <= col_start_d;
    row_start_q <= row_start_d;
    col_mag_q   <= col_mag_d;
    row_mag_q   <= row_mag_d;
    col_neg_q   <= col_neg_d;
    row_neg_q   <= row_neg_d;
  end

  // input register
  item_t f1_q;
  logic  f1_vld_q, f1_vld_d;
  logic  in_take, mode_ok, go;

  assign item_full_o = f1_vld_q && cmd_full_i;
  assign go          = f1_vld_q && !cmd_full_i;
  assign mode_ok     = (item_i.mode == MODE_CACHE_WR) || (item_i.mode == MODE_PAL_WR) ||
                       (item_i.mode == MODE_TICK);
  assign in_take     = item_push_i && !item_full_o && mode_ok;

  always_comb begin
    f1_vld_d = f1_vld_q;
    if (in_take) begin
      f1_vld_d = 1'b1;
    end else if (go) begin
      f1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= f1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      f1_q <= item_i;
    end
  end

  // position state
  logic [POS_W-1:0]  cur_col_q, cur_row_q;
  logic [ACC_W-1:0]  col_acc_q, row_acc_q;
  logic [SPAN_W-1:0] col_step_q, row_step_q;
  logic              col_back_q, row_back_q;
  logic [CNT_W-1:0]  dest_col_q, dest_row_q;

  logic              tick, first_col, first_frame, last_col, last_row, row_over;
  logic [POS_W-1:0]  col_pos_u, row_pos_u;
  logic [ACC_W-1:0]  col_acc_u, row_acc_u;
  logic [SPAN_W-1:0] col_step_u, row_step_u;
  logic              col_back_u, row_back_u;
  axis_t             col_adv, row_adv, row_next;
  logic [ADDR_W-1:0] r16, c16, idx;

  always_comb begin
    tick        = (f1_q.mode == MODE_TICK);
    first_col   = (dest_col_q == '0);
    first_frame = first_col && (dest_row_q == '0);

    col_pos_u  = first_col ? col_start_q        : cur_col_q;
    col_acc_u  = first_col ? ACC_W'(col_init_q) : col_acc_q;
    col_step_u = first_col ? col_mag_q          : col_step_q;
    col_back_u = first_col ? col_neg_q          : col_back_q;
    row_pos_u  = first_frame ? row_start_q        : cur_row_q;
    row_acc_u  = first_frame ? ACC_W'(row_init_q) : row_acc_q;
    row_step_u = first_frame ? row_mag_q          : row_step_q;
    row_back_u = first_frame ? row_neg_q          : row_back_q;

    r16 = {{(ADDR_W-10){row_pos_u[POS_W-1]}}, row_pos_u[POS_W-1:8]};
    c16 = {{(ADDR_W-10){col_pos_u[POS_W-1]}}, col_pos_u[POS_W-1:8]};
    idx = ADDR_W'(r16 * CW16 + c16);

    last_col = (DIM_W'(dest_col_q) + DIM_W'(1)) >= w_eff_q;
    last_row = (DIM_W'(dest_row_q) + DIM_W'(1)) >= h_eff_q;

    col_adv = step_axis(col_pos_u, col_acc_u, col_step_u, col_back_u,
                        ACC_W'({w_eff_q, 8'd0}));
    row_adv = step_axis(row_pos_u, row_acc_u, row_step_u, row_back_u,
                        ACC_W'({h_eff_q, 8'd0}));
    row_over = !row_adv.pos[POS_W-1] && (32'(row_adv.pos[POS_W-2:8]) > (CACHE_ROWS - 1));
    row_next = row_adv;
    if (row_over) begin
      row_next.pos = ROW_CLAMP;
    end
    if (!last_col) begin
      row_next.pos = row_pos_u;
      row_next.acc = row_acc_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      col_acc_q  <= '0;
      row_acc_q  <= '0;
      col_step_q <= '0;
      row_step_q <= '0;
      col_back_q <= 1'b0;
      row_back_q <= 1'b0;
      dest_col_q <= '0;
      dest_row_q <= '0;
    end else if (go && tick) begin
      cur_col_q  <= col_adv.pos;
      col_acc_q  <= col_adv.acc;
      col_step_q <= col_step_u;
      col_back_q <= col_back_u;
      cur_row_q  <= row_next.pos;
      row_acc_q  <= row_next.acc;
      row_step_q <= row_step_u;
      row_back_q <= row_back_u;
      if (last_col) begin
        dest_col_q <= '0;
        dest_row_q <= last_row ? '0 : dest_row_q + CNT_W'(1);
      end else begin
        dest_col_q <= dest_col_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    cmd_push_o      = go;
    cmd_o.op        = mode_e'(f1_q.mode);
    cmd_o.addr      = tick ? idx : f1_q.address;
    cmd_o.data      = f1_q.data;
    cmd_o.row_end   = tick && last_col;
    cmd_o.frame_end = tick && last_col && last_row;
  end

  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && tick && last_col |=> dest_col_q == '0)
    else $error("column counter not restarted after row end");

endmodule

`default_nettype wire

FILE: src/pmns_back.sv
// Back end: cache and palette lookups in two RAM stages, result buffer.
// Depends on pmns_pkg, pmns_ram and pmns_fifo.
`timescale 1ns / 1ps
`default_nettype none

module pmns_back import pmns_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    cmd_empty_i,
  input  wire cmd_t    cmd_i,
  output logic         cmd_pop_o,
  output logic         res_empty_o,
  output result_t      res_o,
  input  wire logic    res_pop_i
);

  localparam int unsigned CRED_W = $clog2(OUT_DEPTH + 1);

  logic [CRED_W-1:0] cred_q, cred_d;
  logic              issue, issue_tick, head_tick, res_taken;
  cmd_t              s1_q;
  logic              s1_vld_q;
  logic              s2_vld_q, s2_row_end_q, s2_frame_end_q;
  logic [BYTE_W-1:0] cache_rdata, pal_rdata, pal_addr;
  logic              out_full;
  result_t           out_wdata;

  assign head_tick  = (cmd_i.op == MODE_TICK);
  assign issue      = !cmd_empty_i && (!head_tick || (cred_q < CRED_W'(OUT_DEPTH)));
  assign issue_tick = issue && head_tick;
  assign cmd_pop_o  = issue;
  assign res_taken  = res_pop_i && !res_empty_o;

  always_comb begin
    cred_d = cred_q;
    if (issue_tick && !res_taken) begin
      cred_d = cred_q + CRED_W'(1);
    end else if (res_taken && !issue_tick) begin
      cred_d = cred_q - CRED_W'(1);
    end
  end

  pmns_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CACHE_DEPTH)
  ) u_cache (
    .clk_i   (clk_i),
    .en_i    (issue),
    .we_i    (cmd_i.op == MODE_CACHE_WR),
    .addr_i  (cmd_i.addr),
    .wdata_i (cmd_i.data),
    .rdata_o (cache_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      cred_q   <= cred_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q && (s1_q.op == MODE_TICK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q <= cmd_i;
    end
    s2_row_end_q   <= s1_q.row_end;
    s2_frame_end_q <= s1_q.frame_end;
  end

  assign pal_addr = (s1_q.op == MODE_TICK) ? cache_rdata : s1_q.addr[BYTE_W-1:0];

  pmns_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .en_i    (s1_vld_q),
    .we_i    (s1_q.op == MODE_PAL_WR),
    .addr_i  (pal_addr),
    .wdata_i (s1_q.data),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    out_wdata.pixel     = pal_rdata;
    out_wdata.row_end   = s2_row_end_q;
    out_wdata.frame_end = s2_frame_end_q;
  end

  pmns_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_vld_q),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (res_pop_i),
    .rdata_o (res_o),
    .empty_o (res_empty_o)
  );

  a_cred_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= CRED_W'(OUT_DEPTH))
    else $error("result credit count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> !out_full)
    else $error("result buffer written while full");

  a_tick_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_tick |=> s1_vld_q ##1 s2_vld_q)
    else $error("pixel lookup lost in pipeline");

endmodule

`default_nettype wire

FILE: src/palette_mapped_nearest_scaler_top.sv
// Top level of the palette-mapped nearest-neighbour scaler: register port,
// front end, command queue and back end. Depends on pmns_pkg, pmns_front,
// pmns_fifo and pmns_back.
//
//   port group   direction  transfer when
//   item         in         push && !full
//   result       out        pop && !empty
//   registers    in/out     psel && penable (pready tied high)
//
// One item per cycle while full stays low; a tick's pixel passes the input
// register, command queue, cache RAM and palette RAM to the result buffer.
// Reset clears counters and positions; cache and palette are not cleared.
// A stalled result side fills the 4-entry result buffer, then the 2-entry
// command queue and the input register before full rises.
`timescale 1ns / 1ps
`default_nettype none

module palette_mapped_nearest_scaler_top import pmns_pkg::*; #(
  parameter int unsigned CACHE_WIDTH = CACHE_WIDTH_DEF,
  parameter int unsigned CACHE_ROWS  = CACHE_ROWS_DEF,
  parameter int unsigned MAX_SCREEN  = MAX_SCREEN_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  input  wire item_t               item_i,
  output logic                     full,
  output logic                     empty,
  output result_t                  result_o,
  input  wire logic                pop,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_e'(paddr[PADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_START_COL:     cfg_d.start_col_fp8 = pwdata[START_W-1:0];
        REG_START_ROW:     cfg_d.start_row_fp8 = pwdata[START_W-1:0];
        REG_SPAN_COLS:     cfg_d.span_cols_fp8 = pwdata[SPAN_W-1:0];
        REG_SPAN_ROWS:     cfg_d.span_rows_fp8 = pwdata[SPAN_W-1:0];
        REG_SCREEN_WIDTH:  cfg_d.screen_width  = pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: cfg_d.screen_height = pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_COL:     prdata = PDATA_W'({1'b0, cfg_q.start_col_fp8});
      REG_START_ROW:     prdata = PDATA_W'({1'b0, cfg_q.start_row_fp8});
      REG_SPAN_COLS:     prdata = PDATA_W'({1'b0, cfg_q.span_cols_fp8});
      REG_SPAN_ROWS:     prdata = PDATA_W'({1'b0, cfg_q.span_rows_fp8});
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(cfg_q.screen_width);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(cfg_q.screen_height);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_col_fp8 <= '0;
      cfg_q.start_row_fp8 <= '0;
      cfg_q.span_cols_fp8 <= '0;
      cfg_q.span_rows_fp8 <= '0;
      cfg_q.screen_width  <= SIZE_RESET;
      cfg_q.screen_height <= SIZE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;

  pmns_front #(
    .CACHE_WIDTH (CACHE_WIDTH),
    .CACHE_ROWS  (CACHE_ROWS),
    .MAX_SCREEN  (MAX_SCREEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_push_i (push),
    .item_i      (item_i),
    .item_full_o (full),
    .cfg_i       (cfg_q),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  pmns_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  pmns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_empty_o (empty),
    .res_o       (result_o),
    .res_pop_i   (pop)
  );

endmodule

`default_nettype wire

FILE: test/tb_palette_mapped_nearest_scaler_top.sv
// Testbench for palette_mapped_nearest_scaler_top: queued item driver and result monitor,
// APB register set-up per phase and a built-in raster predictor checked per transfer.
// Depends on pmns_pkg and the scaler RTL only.
`timescale 1ns / 1ps

module tb_palette_mapped_nearest_scaler_top;
  import pmns_pkg::*;

  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [ACC_W-1:0]  acc;
    logic [SPAN_W-1:0] stride;
    logic              back;
  } sweep_t;

  typedef struct packed {
    sweep_t      col;
    sweep_t      row;
    logic [31:0] dcol;
    logic [31:0] drow;
  } raster_t;

  logic               clk_i;
  logic               rst_ni   = 1'b0;
  logic               push     = 1'b0;
  item_t              item_drv = '0;
  logic               full;
  logic               empty;
  result_t            result_o;
  logic               pop      = 1'b0;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  palette_mapped_nearest_scaler_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_drv),
    .full     (full),
    .empty    (empty),
    .result_o (result_o),
    .pop      (pop),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  item_t             pending_items[$];
  result_t           expected_pixels[$];
  cfg_t              cfg_now;
  raster_t           plan_raster;
  raster_t           live_raster;
  logic [BYTE_W-1:0] live_cache[CACHE_DEPTH];
  logic [BYTE_W-1:0] live_palette[PAL_DEPTH];
  logic [BYTE_W-1:0] plan_cache[CACHE_DEPTH];
  bit                plan_cache_set[CACHE_DEPTH];
  bit                plan_pal_set[PAL_DEPTH];
  logic [ADDR_W-1:0] plan_last_idx = '0;
  int unsigned       fail_count = 0;
  int unsigned       send_gap = 0;
  int unsigned       take_gap = 0;
  int unsigned       quiet = 0;
  bit                send_burst = 1'b0;
  bit                take_burst = 1'b0;
  bit                long_hold_armed = 1'b0;
  bit                long_hold_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [ACC_W-1:0] screen_size(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SCREEN_DEF) return MAX_SCREEN_DEF;
    return ACC_W'(v);
  endfunction

  // latch position, step and direction at the start of a row or frame
  function automatic sweep_t sweep_start(logic [START_W-1:0] start, logic [SPAN_W-1:0] span,
                                         logic [ACC_W-1:0] size);
    sweep_t            s;
    logic [ACC_W-1:0]  offset;
    logic [SPAN_W-1:0] mag;
    offset = ACC_W'(start[7:0]) * size;
    mag    = -span;
    s.pos  = {start[START_W-1], start};
    s.back = span[SPAN_W-1];
    s.stride = s.back ? mag : span;
    s.acc  = s.back ? size * 256 - offset : offset;
    return s;
  endfunction

  function automatic sweep_t sweep_move(sweep_t s, logic [ACC_W-1:0] limit);
    logic [ACC_W:0] total;
    total = {1'b0, s.acc} + (ACC_W+1)'(s.stride);
    s.acc = total[ACC_W] ? '1 : total[ACC_W-1:0];
    if (s.acc > limit) begin
      s.acc = s.acc - limit;
      s.pos = s.back ? s.pos - ONE_FP8 : s.pos + ONE_FP8;
    end
    return s;
  endfunction

  function automatic logic signed [9:0] whole_px(logic [POS_W-1:0] p);
    return p[POS_W-1:8];
  endfunction

  function automatic void raster_tick(inout raster_t r, input cfg_t c,
                                      output logic [ADDR_W-1:0] idx,
                                      output logic row_end, output logic frame_end);
    logic [ACC_W-1:0] w;
    logic [ACC_W-1:0] h;
    logic             last_row;
    logic signed [9:0] ri;
    w = screen_size(c.screen_width);
    h = screen_size(c.screen_height);
    if (r.dcol == 0 && r.drow == 0) r.row = sweep_start(c.start_row_fp8, c.span_rows_fp8, h);
    if (r.dcol == 0) r.col = sweep_start(c.start_col_fp8, c.span_cols_fp8, w);
    idx = ADDR_W'(int'(whole_px(r.row.pos)) * int'(CACHE_WIDTH_DEF)
                  + int'(whole_px(r.col.pos)));
    row_end  = (r.dcol + 1 >= w);
    last_row = (r.drow + 1 >= h);
    r.col = sweep_move(r.col, w * 256);
    if (row_end) begin
      r.dcol = 0;
      r.row  = sweep_move(r.row, h * 256);
      ri = whole_px(r.row.pos);
      // clamp at the last cache row, negative rows pass through
      if (int'(ri) > int'(CACHE_ROWS_DEF) - 1) r.row.pos = POS_W'((CACHE_ROWS_DEF - 1) * 256);
      r.drow = last_row ? 0 : r.drow + 1;
    end else begin
      r.dcol = r.dcol + 1;
    end
    frame_end = row_end && last_row;
  endfunction

  function automatic void take_item(item_t it);
    logic [ADDR_W-1:0] idx;
    logic              re;
    logic              fe;
    result_t           want;
    case (it.mode)
      MODE_CACHE_WR: live_cache[it.address] = it.data;
      MODE_PAL_WR:   live_palette[it.address[BYTE_W-1:0]] = it.data;
      MODE_TICK: begin
        raster_tick(live_raster, cfg_now, idx, re, fe);
        want.pixel     = live_palette[live_cache[idx]];
        want.row_end   = re;
        want.frame_end = fe;
        expected_pixels.push_back(want);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_pixel(result_t got);
    result_t want;
    if (expected_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected pixel %02h row_end %0b frame_end %0b", $realtime,
                 got.pixel, got.row_end, got.frame_end);
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel !== want.pixel || got.row_end !== want.row_end ||
          got.frame_end !== want.frame_end) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: pixel mismatch, expected %02h/%0b/%0b, got %02h/%0b/%0b", $realtime,
                   want.pixel, want.row_end, want.frame_end,
                   got.pixel, got.row_end, got.frame_end);
      end
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void plan_item(item_t it);
    pending_items.push_back(it);
    case (it.mode)
      MODE_CACHE_WR: begin
        plan_cache[it.address]     = it.data;
        plan_cache_set[it.address] = 1'b1;
      end
      MODE_PAL_WR: plan_pal_set[it.address[BYTE_W-1:0]] = 1'b1;
      default: ;
    endcase
  endfunction

  // a tick, preceded by the writes it needs so that nothing unwritten is read
  function automatic void plan_tick();
    logic [ADDR_W-1:0] idx;
    logic              re;
    logic              fe;
    raster_tick(plan_raster, cfg_now, idx, re, fe);
    if (!plan_cache_set[idx])
      plan_item(item_t'{MODE_CACHE_WR, idx, BYTE_W'($urandom)});
    if (!plan_pal_set[plan_cache[idx]])
      plan_item(item_t'{MODE_PAL_WR, {BYTE_W'($urandom), plan_cache[idx]}, BYTE_W'($urandom)});
    plan_item(item_t'{MODE_TICK, ADDR_W'($urandom), BYTE_W'($urandom)});
    plan_last_idx = idx;
  endfunction

  function automatic void plan_random();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65)
      plan_tick();
    else if (pick < 80)
      plan_item(item_t'{MODE_CACHE_WR, $urandom_range(0, 1) ? plan_last_idx : ADDR_W'($urandom),
                        BYTE_W'($urandom)});
    else if (pick < 95)
      plan_item(item_t'{MODE_PAL_WR, ADDR_W'($urandom), BYTE_W'($urandom)});
    else
      plan_item(item_t'{MODE_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom)});
  endfunction

  function automatic cfg_t make_config(int sc, int sr, int spc, int spr, int w, int h);
    cfg_t c;
    c.start_col_fp8 = START_W'(sc);
    c.start_row_fp8 = START_W'(sr);
    c.span_cols_fp8 = SPAN_W'(spc);
    c.span_rows_fp8 = SPAN_W'(spr);
    c.screen_width  = SIZE_W'(w);
    c.screen_height = SIZE_W'(h);
    return c;
  endfunction

  function automatic cfg_t random_config();
    cfg_t        c;
    int unsigned reach;
    c.screen_width  = SIZE_W'($urandom_range(0, 8));
    c.screen_height = SIZE_W'($urandom_range(0, 6));
    c.start_col_fp8 = START_W'($urandom);
    c.start_row_fp8 = START_W'($urandom);
    reach = 256 * $urandom_range(1, 24);
    c.span_cols_fp8 = SPAN_W'($urandom_range(0, 2 * reach) - reach);
    c.span_rows_fp8 = SPAN_W'($urandom_range(0, 2 * reach) - reach);
    if ($urandom_range(0, 3) == 0) c.span_cols_fp8 = SPAN_W'($urandom);
    return c;
  endfunction

  task automatic write_reg(reg_e which, logic [PDATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * which);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(REG_START_COL,
              {{(PDATA_W-START_W){c.start_col_fp8[START_W-1]}}, c.start_col_fp8});
    write_reg(REG_START_ROW,
              {{(PDATA_W-START_W){c.start_row_fp8[START_W-1]}}, c.start_row_fp8});
    write_reg(REG_SPAN_COLS, {{(PDATA_W-SPAN_W){c.span_cols_fp8[SPAN_W-1]}}, c.span_cols_fp8});
    write_reg(REG_SPAN_ROWS, {{(PDATA_W-SPAN_W){c.span_rows_fp8[SPAN_W-1]}}, c.span_rows_fp8});
    write_reg(REG_SCREEN_WIDTH, PDATA_W'(c.screen_width));
    write_reg(REG_SCREEN_HEIGHT, PDATA_W'(c.screen_height));
    cfg_now = c;
    @(negedge clk_i);
  endtask

  // sender holds off until every pixel is back and the pipeline has drained
  task automatic settle();
    do @(negedge clk_i); while (pending_items.size() != 0 || push || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver / monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push       <= 1'b0;
      item_drv   <= '0;
      send_gap   <= 0;
      send_burst <= 1'b0;
    end else if (!(push && full)) begin
      if (push) take_item(item_drv);
      if ($urandom_range(0, 63) == 0) send_burst <= !send_burst;
      if (send_gap != 0) begin
        push     <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        item_drv <= pending_items.pop_front();
        push     <= 1'b1;
        send_gap <= send_burst ? 0 : $urandom_range(0, 7);
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      take_gap   <= 0;
      take_burst <= 1'b0;
    end else if (!(pop && empty)) begin
      if (pop) check_pixel(result_o);
      if ($urandom_range(0, 63) == 0) take_burst <= !take_burst;
      if (take_gap != 0) begin
        pop      <= 1'b0;
        take_gap <= take_gap - 1;
      end else begin
        pop <= 1'b1;
        if (long_hold_armed && !long_hold_done) begin
          take_gap       <= LONG_HOLD;
          long_hold_done <= 1'b1;
        end else begin
          take_gap <= take_burst ? 0 : $urandom_range(0, 7);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    cfg_now     = make_config(0, 0, 0, 0, 160, 160);
    plan_raster = '0;
    live_raster = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: every pixel maps to cache entry zero
    plan_item(item_t'{MODE_UNUSED, 16'hFFFF, 8'hFF});
    plan_item(item_t'{MODE_UNUSED, 16'h0000, 8'h00});
    plan_item(item_t'{MODE_CACHE_WR, 16'hFFFF, 8'hFF});
    plan_item(item_t'{MODE_CACHE_WR, 16'h0000, 8'h00});
    plan_item(item_t'{MODE_PAL_WR, 16'hFFFF, 8'hFF});
    plan_item(item_t'{MODE_PAL_WR, 16'h0000, 8'h00});
    plan_tick();
    plan_tick();
    plan_item(item_t'{MODE_CACHE_WR, 16'h0000, 8'hFF});
    plan_tick();
    plan_item(item_t'{MODE_PAL_WR, 16'hFF00, 8'h5A});
    plan_item(item_t'{MODE_CACHE_WR, 16'h0000, 8'h00});
    plan_tick();
    repeat (40) plan_random();
    settle();

    apply_config(make_config(2688, 832, 768, 512, 4, 3));
    repeat (60) plan_random();
    settle();

    apply_config(make_config(-384, 65408, -1792, -1280, 5, 4));
    repeat (60) plan_random();
    settle();

    // extreme starts and spans, one pixel per frame; ends on a frame boundary
    apply_config(make_config(-65536, 65535, -8388608, 8388607, 1, 1));
    repeat (30) plan_random();
    plan_tick();
    settle();

    // zero width, oversized height: rows walk down past the wrap and the
    // row accumulator saturates before the frame ends
    apply_config(make_config(int'($urandom_range(0, 65535)), -65536, int'($urandom),
                             -8388608, 0, 2047));
    repeat (570) plan_tick();
    settle();

    // widest screen, left mid-row so that the next narrow screen cuts it short
    apply_config(make_config(65535, -65536, 8388607, -8388608, 1024, 2));
    repeat (30) plan_random();
    settle();

    apply_config(make_config(int'($urandom), int'($urandom), 1000, -700, 3, 2));
    repeat (40) plan_random();
    settle();

    long_hold_armed = 1'b1;
    repeat (4) begin
      apply_config(random_config());
      repeat (60) plan_random();
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: palette_mapped_nearest_scaler_top.f
src/pmns_pkg.sv
src/pmns_ram.sv
src/pmns_fifo.sv
src/pmns_front.sv
src/pmns_back.sv
src/palette_mapped_nearest_scaler_top.sv
test/tb_palette_mapped_nearest_scaler_top.sv
